// ===== rtl/imufrm_pkg.sv =====
`timescale 1ns / 1ps
// package for the imu sample packet framer: payload types, queue entry,
// packet layout constants and the crc16 byte update; no dependencies
package imufrm_pkg;

  localparam int PKT_LEN     = 26;
  localparam int CRC_SPAN    = 24;
  localparam int IDX_W       = $clog2(PKT_LEN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_0   = 8'h55;
  localparam logic [7:0]  SYNC_1   = 8'hAA;

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PKT_LEN - 1);

  typedef struct packed {
    logic [63:0]        timestamp_us;
    logic signed [15:0] temperature;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } sample_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] packet_count;
    logic [31:0] fsync_count;
  } result_t;

  typedef struct packed {
    sample_t     sample;
    logic [31:0] packet_count;
    logic [31:0] fsync_count;
  } entry_t;

  typedef struct packed {
    logic                valid;
    logic                full;
    logic [QUEUE_AW:0]   count;
  } q_status_t;

  // one byte of crc16-ccitt, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // header and payload bytes 0..23 of a packet, byte i at bits 8*i
  function automatic logic [8*CRC_SPAN-1:0] pkt_body(input sample_t s);
    return {s.temperature, s.gyro_z, s.gyro_y, s.gyro_x,
            s.accel_z, s.accel_y, s.accel_x, s.timestamp_us, SYNC_1, SYNC_0};
  endfunction

endpackage

// ===== rtl/imufrm_front.sv =====
`timescale 1ns / 1ps
// front end: takes samples, counts packets and fsync tags, builds queue entries
// depends on imufrm_pkg
module imufrm_front import imufrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sample_t   in_data,
  input  q_status_t q_stat,
  output logic      push,
  output entry_t    push_entry
);

  logic [31:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [31:0] fsync_cnt_r, fsync_cnt_nxt;
  logic        fsync_tag;

  assign in_ready  = !q_stat.full;
  assign push      = in_valid && in_ready;
  assign fsync_tag = in_data.temperature[0];

  always_comb begin
    pkt_cnt_nxt   = pkt_cnt_r;
    fsync_cnt_nxt = fsync_cnt_r;
    if (push) begin
      pkt_cnt_nxt   = pkt_cnt_r + 32'd1;
      fsync_cnt_nxt = fsync_cnt_r + {31'd0, fsync_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_cnt_r   <= '0;
      fsync_cnt_r <= '0;
    end else begin
      pkt_cnt_r   <= pkt_cnt_nxt;
      fsync_cnt_r <= fsync_cnt_nxt;
    end
  end

  // entries carry the counts as updated by this sample
  assign push_entry.sample       = in_data;
  assign push_entry.packet_count = pkt_cnt_nxt;
  assign push_entry.fsync_count  = fsync_cnt_nxt;

endmodule

// ===== rtl/imufrm_queue.sv =====
`timescale 1ns / 1ps
// small entry queue between the front end and the serializer
// depends on imufrm_pkg
module imufrm_queue import imufrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t q_stat
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_stat.count = count_r;

endmodule

// ===== rtl/imufrm_back.sv =====
`timescale 1ns / 1ps
// serializer: walks the head entry byte by byte, runs the crc, drives the
// registered output stage; depends on imufrm_pkg
module imufrm_back import imufrm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_data
);

  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_data_r, out_data_nxt;
  logic                  issue;
  logic [8*CRC_SPAN-1:0] body;
  logic [7:0]            cur_byte;
  logic [15:0]           crc_base;

  assign issue = q_stat.valid && (!out_valid_r || out_ready);
  assign pop   = issue && (idx_r == IDX_LAST);
  assign body  = pkt_body(head.sample);

  always_comb begin
    crc_base = (idx_r == '0) ? CRC_INIT : crc_r;
    if (idx_r == IDX_CRC_LO) begin
      cur_byte = crc_r[7:0];
    end else if (idx_r == IDX_LAST) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = body[{idx_r, 3'b000} +: 8];
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (issue) begin
      idx_nxt                   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_byte     = cur_byte;
      out_data_nxt.last_byte    = (idx_r == IDX_LAST);
      out_data_nxt.packet_count = head.packet_count;
      out_data_nxt.fsync_count  = head.fsync_count;
      // crc bytes are not folded into the checksum
      if (idx_r < IDX_CRC_LO) begin
        crc_nxt = crc16_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/imu_sample_packet_framer_crc16.sv =====
`timescale 1ns / 1ps
// top level of the imu sample packet framer; instantiates imufrm_front,
// imufrm_queue and imufrm_back; depends on imufrm_pkg

// Each accepted sample turns into a 26-byte packet on the output channel:
// sync 0x55 0xAA, the 64-bit timestamp, accel x/y/z, gyro x/y/z and
// temperature (all little-endian), then a crc16-ccitt (init 0xffff,
// poly 0x1021) over the first 24 bytes, low byte first. Every byte carries the
// packet and fsync counts as updated by its sample. The serializer puts out
// one byte per cycle while the sink is ready, which sets the sustained rate,
// and with a ready sink packets follow each other with no gap. A two-entry
// queue in front of it takes new samples while a packet is still streaming.
module imu_sample_packet_framer_crc16 import imufrm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;

  imufrm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  imufrm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  imufrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a taken packet end is never directly followed by another packet end
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_byte) |=>
      !(out_valid && out_data.last_byte))
    else $error("last byte repeated");

  // counts stay fixed within a packet
  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_byte) |=>
      (!out_valid || ($stable(out_data.packet_count) && $stable(out_data.fsync_count))))
    else $error("counts changed inside a packet");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue overflow");

  // a pop always has an entry behind it
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for imu_sample_packet_framer_crc16: random and directed imu samples in,
// every 26-byte packet checked byte by byte against a local frame/crc16 predictor
// depends on imufrm_pkg and the framer rtl
module tb_top import imufrm_pkg::*; ();

  localparam int FRAME_BYTES = 26;
  localparam int CRC_BYTES   = 24;
  localparam int MAX_SHOWN   = 10;

  class imu_packet_sb;
    result_t     pending_bytes[$];
    logic [31:0] packets_sent;
    logic [31:0] fsync_tags_seen;
    int          errors;

    function new();
      packets_sent    = '0;
      fsync_tags_seen = '0;
      errors          = 0;
    endfunction

    // builds the frame an accepted sample must turn into
    function void note_sample(sample_t s);
      logic [7:0]  frame[FRAME_BYTES];
      logic [15:0] words[7];
      logic [15:0] crc;
      result_t     r;
      words = '{s.accel_x, s.accel_y, s.accel_z, s.gyro_x, s.gyro_y, s.gyro_z,
                s.temperature};
      frame[0] = 8'h55;
      frame[1] = 8'hAA;
      for (int i = 0; i < 8; i++) frame[2 + i] = s.timestamp_us[8*i +: 8];
      for (int w = 0; w < 7; w++) begin
        frame[10 + 2*w] = words[w][7:0];
        frame[11 + 2*w] = words[w][15:8];
      end
      crc = 16'hFFFF;
      for (int i = 0; i < CRC_BYTES; i++) begin
        crc = crc ^ {frame[i], 8'h00};
        for (int b = 0; b < 8; b++) begin
          crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
        end
      end
      frame[24] = crc[7:0];
      frame[25] = crc[15:8];
      packets_sent = packets_sent + 32'd1;
      if (s.temperature[0]) fsync_tags_seen = fsync_tags_seen + 32'd1;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        r.out_byte     = frame[i];
        r.last_byte    = (i == FRAME_BYTES - 1);
        r.packet_count = packets_sent;
        r.fsync_count  = fsync_tags_seen;
        pending_bytes.push_back(r);
      end
    endfunction

    function void check_byte(result_t got);
      result_t exp;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected byte %h last %b pkt %0d fsync %0d", $realtime,
                   got.out_byte, got.last_byte, got.packet_count, got.fsync_count);
        return;
      end
      exp = pending_bytes.pop_front();
      if (got.out_byte !== exp.out_byte || got.last_byte !== exp.last_byte ||
          got.packet_count !== exp.packet_count || got.fsync_count !== exp.fsync_count)
      begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: byte mismatch exp %h/%b/%0d/%0d got %h/%b/%0d/%0d", $realtime,
                   exp.out_byte, exp.last_byte, exp.packet_count, exp.fsync_count,
                   got.out_byte, got.last_byte, got.packet_count, got.fsync_count);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_data;
  logic    out_valid;
  logic    out_ready;
  result_t out_data;

  imu_packet_sb sb = new();
  bit           steady_flow;

  imu_sample_packet_framer_crc16 i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // raw sensor word, biased toward the extremes now and then
  function automatic logic [15:0] sensor_word();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  // result side: bursts of ready separated by random stalls
  initial begin : sink
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_byte(out_data);
      if (steady_flow) begin
        out_ready <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        run_left   = $urandom_range(0, 40);
        stall_left = idle_len();
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sample_t     s;
    logic [63:0] ts_now;
    in_valid    = 1'b0;
    in_data     = '0;
    steady_flow = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);

    send_sample({64'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000});
    send_sample({64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_sample({64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample({64'h8000_0000_0000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000});
    send_sample({64'h0123_4567_89AB_CDEF, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                 16'h0001, 16'h0001, 16'h0001});
    send_sample({64'h5555_5555_5555_5555, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555,
                 16'h5555, 16'h5555, 16'h5555});
    send_sample({64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                 16'hAAAA, 16'hAAAA, 16'hAAAA});
    send_sample({64'h1, 16'hFFFE, 16'h1234, 16'h8001, 16'h7FFE, 16'hFEDC,
                 16'h0080, 16'hFF00});

    // back-to-back samples with a ready sink fill the input queue; fsync alternates
    steady_flow = 1'b1;
    for (int i = 0; i < 8; i++) begin
      s = {{$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      s.temperature[0] = i[0];
      send_sample(s);
    end
    steady_flow = 1'b0;

    ts_now = {$urandom, $urandom};
    for (int k = 0; k < 214; k++) begin
      steady_flow = ((k / 58) == 2);
      if ($urandom_range(0, 9) < 7) ts_now = ts_now + 64'($urandom_range(1, 5000));
      else ts_now = {$urandom, $urandom};
      s = {ts_now, sensor_word(), sensor_word(), sensor_word(), sensor_word(),
           sensor_word(), sensor_word(), sensor_word()};
      send_sample(s);
    end
    in_valid    <= 1'b0;
    steady_flow = 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/imufrm_pkg.sv
rtl/imufrm_front.sv
rtl/imufrm_queue.sv
rtl/imufrm_back.sv
rtl/imu_sample_packet_framer_crc16.sv
test/tb_top.sv
